>>> rtl/mxt_pkg.sv
// Package for the maximum XOR pair trie block.
// Holds the default sizes and the input and result word types.
// No dependencies.
`default_nettype none

package mxt_pkg;

  localparam int WORD_BITS_DEF  = 32;
  localparam int MAX_WORDS_DEF  = 255;
  localparam int NODE_COUNT_DEF = 8192;

  typedef struct packed {
    logic [31:0] value;
    logic        first;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [31:0] max_xor;
    logic        dropped;
    logic [7:0]  word_count;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/mxt_node_ram.sv
// Node store of the trie: one write port, one read port, registered read data.
// Each entry holds the two child links of one node. No dependencies.
`default_nettype none

module mxt_node_ram #(
  parameter int DEPTH     = 8192,
  parameter int ADDR_BITS = 13,
  parameter int DATA_BITS = 26
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_BITS-1:0] wr_addr,
  input  wire logic [DATA_BITS-1:0] wr_data,
  input  wire logic [ADDR_BITS-1:0] rd_addr,
  output logic      [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/max_xor_pair_trie.sv
// Maximum XOR pair trie: top level with the walk and insert sequencer.
// Depends on mxt_pkg and mxt_node_ram.
// Per word: a prefix walk, a partner query walk when the set is not empty, an insert of
// the new path unless the word is already stored, then a finish step. A word that does
// not fit is dropped. One word is in flight at a time; the walk goes one trie level per
// cycle through the single read port of the node store; a stalled result holds the finish state.
// Reset (synchronous) clears the set at once; the root node lives in flip-flops and the
// node store needs no clearing pass.
`default_nettype none

module max_xor_pair_trie #(
  parameter int WORD_BITS  = mxt_pkg::WORD_BITS_DEF,
  parameter int MAX_WORDS  = mxt_pkg::MAX_WORDS_DEF,
  parameter int NODE_COUNT = mxt_pkg::NODE_COUNT_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  output logic                 item_ready,
  input  wire mxt_pkg::item_t  item_data,
  output logic                 result_valid,
  input  wire logic            result_ready,
  output mxt_pkg::result_t     result_data
);

  localparam int NB       = $clog2(NODE_COUNT);
  localparam int EB       = 2 * NB;
  localparam int LB       = $clog2(WORD_BITS);
  localparam int CB       = $clog2(MAX_WORDS + 1);
  localparam int SB       = NB + 2;
  localparam int EXT_BITS = (WORD_BITS > 32) ? WORD_BITS : 32;
  localparam int CNT_EXT  = (CB > 8) ? CB : 8;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_PFX     = 6'b000010,
    ST_QRY     = 6'b000100,
    ST_INS_BRK = 6'b001000,
    ST_INS_NEW = 6'b010000,
    ST_FIN     = 6'b100000
  } state_t;

  state_t                state;
  logic [WORD_BITS-1:0]  w;
  logic                  last_r;
  logic [LB-1:0]         lvl;
  logic [NB-1:0]         node;
  logic                  cur_root;
  logic [EB-1:0]         root;
  logic [NB:0]           next_free;
  logic [CB-1:0]         stored;
  logic [WORD_BITS-1:0]  best;
  logic [WORD_BITS-1:0]  acc;
  logic                  drop;
  logic [LB-1:0]         brk_lvl;
  logic                  brk_dup;
  logic                  brk_root;
  logic [NB-1:0]         brk_node;
  logic [EB-1:0]         brk_ent;

  logic [EB-1:0]         rd_data;
  logic [NB-1:0]         rd_addr;
  logic                  wr_en;
  logic [NB-1:0]         wr_addr;
  logic [EB-1:0]         wr_data;

  logic [EB-1:0]         ent;
  logic                  bit_cur;
  logic [NB-1:0]         link_same;
  logic [NB-1:0]         link_opp;
  logic                  pfx_hit;
  logic                  pfx_end;
  logic [LB:0]           pfx_need;
  logic                  room;
  logic                  full;
  logic                  qry_stop;
  logic [NB-1:0]         qry_nx;
  logic [WORD_BITS-1:0]  acc_next;
  logic [LB-1:0]         lvl_dn;
  logic [NB-1:0]         nf;
  logic [NB:0]           nf_inc;
  logic [EB-1:0]         brk_new;
  logic [EB-1:0]         new_ent;
  logic [EXT_BITS-1:0]   value_ext;
  logic [EXT_BITS-1:0]   best_ext;
  logic [CNT_EXT-1:0]    cnt_ext;

  assign item_ready = (state == ST_IDLE);
  assign value_ext  = EXT_BITS'(item_data.value);
  assign best_ext   = EXT_BITS'(best);
  assign cnt_ext    = CNT_EXT'(stored);

  assign ent       = cur_root ? root : rd_data;
  assign bit_cur   = w[lvl];
  assign link_same = bit_cur ? ent[EB-1:NB] : ent[NB-1:0];
  assign link_opp  = bit_cur ? ent[NB-1:0] : ent[EB-1:NB];

  assign pfx_hit  = (link_same != '0);
  assign pfx_end  = !pfx_hit || (lvl == '0);
  assign pfx_need = pfx_hit ? '0 : ({1'b0, lvl} + (LB+1)'(1));
  assign room     = (SB'(next_free) + SB'(pfx_need)) <= SB'(NODE_COUNT);
  assign full     = (stored >= CB'(MAX_WORDS));

  assign qry_nx   = (link_opp != '0) ? link_opp : link_same;
  assign qry_stop = ((link_opp == '0) && (link_same == '0)) || (lvl == '0);
  assign acc_next = acc | ((link_opp != '0) ? (WORD_BITS'(1) << lvl) : '0);

  assign lvl_dn = lvl - LB'(1);
  assign nf     = next_free[NB-1:0];
  assign nf_inc = next_free + (NB+1)'(1);

  assign brk_new = w[brk_lvl] ? {nf, brk_ent[NB-1:0]} : {brk_ent[EB-1:NB], nf};

  always_comb begin
    new_ent = '0;
    if (lvl != '0) begin
      if (w[lvl_dn]) begin
        new_ent[EB-1:NB] = nf_inc[NB-1:0];
      end else begin
        new_ent[NB-1:0] = nf_inc[NB-1:0];
      end
    end
  end

  assign rd_addr = (state == ST_QRY) ? qry_nx : link_same;
  assign wr_en   = ((state == ST_INS_BRK) && !brk_root) || (state == ST_INS_NEW);
  assign wr_addr = (state == ST_INS_BRK) ? brk_node : nf;
  assign wr_data = (state == ST_INS_BRK) ? brk_new : new_ent;

  mxt_node_ram #(
    .DEPTH     (NODE_COUNT),
    .ADDR_BITS (NB),
    .DATA_BITS (EB)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      root         <= '0;
      next_free    <= (NB+1)'(1);
      stored       <= '0;
      best         <= '0;
      drop         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_ready && !((state == ST_FIN) && last_r)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            w        <= value_ext[WORD_BITS-1:0];
            last_r   <= item_data.last;
            lvl      <= LB'(WORD_BITS - 1);
            node     <= '0;
            cur_root <= 1'b1;
            if (item_data.first) begin
              root      <= '0;
              next_free <= (NB+1)'(1);
              stored    <= '0;
              best      <= '0;
              drop      <= 1'b0;
            end
            state <= ST_PFX;
          end
        end
        ST_PFX: begin
          if (pfx_end) begin
            brk_lvl  <= lvl;
            brk_dup  <= pfx_hit;
            brk_node <= node;
            brk_ent  <= ent;
            brk_root <= cur_root;
            if (full || !room) begin
              drop  <= 1'b1;
              state <= ST_FIN;
            end else begin
              stored <= stored + CB'(1);
              if (stored != '0) begin
                lvl      <= LB'(WORD_BITS - 1);
                node     <= '0;
                cur_root <= 1'b1;
                acc      <= '0;
                state    <= ST_QRY;
              end else begin
                state <= pfx_hit ? ST_FIN : ST_INS_BRK;
              end
            end
          end else begin
            node     <= link_same;
            cur_root <= 1'b0;
            lvl      <= lvl_dn;
          end
        end
        ST_QRY: begin
          acc <= acc_next;
          if (qry_stop) begin
            if (acc_next > best) begin
              best <= acc_next;
            end
            state <= brk_dup ? ST_FIN : ST_INS_BRK;
          end else begin
            node     <= qry_nx;
            cur_root <= 1'b0;
            lvl      <= lvl_dn;
          end
        end
        ST_INS_BRK: begin
          if (brk_root) begin
            root <= brk_new;
          end
          lvl   <= brk_lvl;
          state <= ST_INS_NEW;
        end
        ST_INS_NEW: begin
          next_free <= nf_inc;
          if (lvl == '0) begin
            state <= ST_FIN;
          end else begin
            lvl <= lvl_dn;
          end
        end
        ST_FIN: begin
          if (!last_r) begin
            state <= ST_IDLE;
          end else if (!result_valid || result_ready) begin
            result_data.max_xor    <= best_ext[31:0];
            result_data.dropped    <= drop;
            result_data.word_count <= cnt_ext[7:0];
            result_valid           <= 1'b1;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    SB'(next_free) <= SB'(NODE_COUNT))
    else $error("node allocator ran past the store");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stored <= CB'(MAX_WORDS))
    else $error("stored word count above capacity");

  a_query_pair: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QRY) |-> (stored > CB'(1)))
    else $error("partner query without a stored partner");

  a_no_dup_insert: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS_BRK) |-> !brk_dup)
    else $error("insert started for a word already in the trie");

  a_new_node: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INS_NEW) |-> ((nf != '0) && (SB'(next_free) < SB'(NODE_COUNT))))
    else $error("new node written outside the free region");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench for max_xor_pair_trie: directed table, then random sets of words.
// Results are checked against an in-bench trie that tracks the best XOR pair.
// Depends on mxt_pkg and the max_xor_pair_trie RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int WB          = mxt_pkg::WORD_BITS_DEF;
  localparam int CAPACITY    = mxt_pkg::MAX_WORDS_DEF;
  localparam int NODES       = mxt_pkg::NODE_COUNT_DEF;
  localparam int WORD_BUDGET = 1000;
  localparam int CALM_TAIL   = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 3 * (2 * WB + 4);

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_ready;
  mxt_pkg::item_t   item_data = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  mxt_pkg::result_t result_data;

  max_xor_pair_trie dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item_data    (item_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Trie tracking the set of words since the last clear
  int unsigned zero_link [NODES];
  int unsigned one_link [NODES];
  int unsigned free_node;
  int unsigned set_size;
  logic [31:0] best_pair;
  bit          set_dropped;

  mxt_pkg::result_t pending_reports[$];
  logic [31:0]      set_values[$];

  typedef struct {
    mxt_pkg::item_t   word;
    bit               typed;
    mxt_pkg::result_t report;
  } directed_row_t;
  directed_row_t directed_rows[$];

  int  mismatch_count = 0;
  int  reports_checked = 0;
  int  drop_reports = 0;
  int  words_fed = 0;
  int  sets_started = 0;
  bit  src_idle_on = 1'b1;
  bit  sink_stall_on = 1'b1;
  bit  hold_off_req = 1'b0;

  function automatic void clear_trie();
    zero_link[0] = 0;
    one_link[0]  = 0;
    free_node    = 1;
    set_size     = 0;
    best_pair    = '0;
    set_dropped  = 1'b0;
  endfunction

  function automatic int unsigned child_of(int unsigned node, bit b);
    return b ? one_link[node % NODES] : zero_link[node % NODES];
  endfunction

  function automatic int unsigned shared_levels(logic [31:0] w);
    int unsigned node, nx, depth;
    node  = 0;
    depth = 0;
    for (int lvl = WB - 1; lvl >= 0; lvl--) begin
      nx = child_of(node, w[lvl]);
      if (nx == 0) break;
      node = nx;
      depth++;
    end
    return depth;
  endfunction

  function automatic logic [31:0] best_partner(logic [31:0] w);
    int unsigned node, opp, same;
    logic [31:0] acc;
    node = 0;
    acc  = '0;
    for (int lvl = WB - 1; lvl >= 0; lvl--) begin
      opp = child_of(node, ~w[lvl]);
      if (opp != 0) begin
        node     = opp;
        acc[lvl] = 1'b1;
      end else begin
        same = child_of(node, w[lvl]);
        if (same == 0) break;
        node = same;
      end
    end
    return acc;
  endfunction

  function automatic void insert_path(logic [31:0] w);
    int unsigned node, nx;
    node = 0;
    for (int lvl = WB - 1; lvl >= 0; lvl--) begin
      nx = child_of(node, w[lvl]);
      if (nx == 0) begin
        nx = free_node % NODES;
        free_node++;
        zero_link[nx] = 0;
        one_link[nx]  = 0;
        if (w[lvl]) one_link[node % NODES] = nx;
        else zero_link[node % NODES] = nx;
      end
      node = nx;
    end
  endfunction

  // Fold one word into the set; return 1 when it yields a report
  function automatic bit absorb_word(mxt_pkg::item_t w, output mxt_pkg::result_t rep);
    int unsigned needed;
    logic [31:0] x;
    if (w.first) clear_trie();
    needed = WB - shared_levels(w.value);
    if (set_size >= CAPACITY || free_node + needed > NODES) begin
      set_dropped = 1'b1;
    end else begin
      if (set_size > 0) begin
        x = best_partner(w.value);
        if (x > best_pair) best_pair = x;
      end
      insert_path(w.value);
      set_size++;
    end
    rep.max_xor    = best_pair;
    rep.dropped    = set_dropped;
    rep.word_count = 8'(set_size);
    return w.last;
  endfunction

  function automatic void table_row(logic [31:0] value, bit first, bit last, bit typed,
                                    logic [31:0] max_xor, bit dropped, logic [7:0] count);
    directed_row_t r;
    r.word.value       = value;
    r.word.first       = first;
    r.word.last        = last;
    r.typed            = typed;
    r.report.max_xor    = max_xor;
    r.report.dropped    = dropped;
    r.report.word_count = count;
    directed_rows.push_back(r);
  endfunction

  function automatic logic [31:0] pick_value(logic [31:0] base);
    logic [31:0] v;
    int unsigned k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = base ^ ($urandom & ((32'h1 << k) - 32'h1));
      7:          v = (set_values.size() != 0) ?
                      set_values[$urandom_range(0, set_values.size() - 1)] : base;
      8:          v = $urandom_range(0, 1) ? '1 : '0;
      default:    v = $urandom_range(0, 1) ? (32'h1 << k) : ~(32'h1 << k);
    endcase
    return v;
  endfunction

  task automatic feed_word(mxt_pkg::item_t w, bit typed, mxt_pkg::result_t typed_report);
    mxt_pkg::result_t rep;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_data  <= w;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    words_fed++;
    if (w.first) begin
      set_values.delete();
      sets_started++;
    end
    set_values.push_back(w.value);
    if (absorb_word(w, rep)) begin
      if (typed) rep = typed_report;
      if (rep.dropped) drop_reports++;
      pending_reports.push_back(rep);
    end
  endtask

  initial begin : stimulus
    mxt_pkg::item_t w;
    logic [31:0]    base;
    int             size_of_set;
    int             set_no;
    bit             keep;
    clear_trie();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    table_row(32'h0000_0007, 0, 1, 1, 32'h0, 0, 8'd1);
    table_row(32'h0000_0000, 1, 0, 0, '0, 0, '0);
    table_row(32'hFFFF_FFFF, 0, 1, 1, 32'hFFFF_FFFF, 0, 8'd2);
    table_row(32'h1234_5678, 1, 1, 1, 32'h0, 0, 8'd1);
    table_row(32'h0000_0005, 1, 0, 0, '0, 0, '0);
    table_row(32'h0000_0005, 0, 1, 1, 32'h0, 0, 8'd2);
    table_row(32'hA5A5_A5A5, 0, 1, 0, '0, 0, '0);
    table_row(32'h8000_0000, 0, 1, 0, '0, 0, '0);
    table_row(32'd3, 1, 0, 0, '0, 0, '0);
    table_row(32'd10, 0, 0, 0, '0, 0, '0);
    table_row(32'd5, 0, 0, 0, '0, 0, '0);
    table_row(32'd25, 0, 0, 0, '0, 0, '0);
    table_row(32'd2, 0, 0, 0, '0, 0, '0);
    table_row(32'd8, 0, 1, 1, 32'd28, 0, 8'd6);
    table_row(32'h0000_0001, 1, 0, 0, '0, 0, '0);
    table_row(32'h0000_0002, 0, 0, 0, '0, 0, '0);
    table_row(32'h5555_5555, 0, 0, 0, '0, 0, '0);
    table_row(32'hAAAA_AAAA, 0, 1, 1, 32'hFFFF_FFFF, 0, 8'd4);
    table_row(32'h0000_0000, 1, 1, 1, 32'h0, 0, 8'd1);
    table_row(32'hFFFF_FFFF, 1, 0, 0, '0, 0, '0);
    table_row(32'hFFFF_FFFF, 0, 1, 1, 32'h0, 0, 8'd2);
    table_row(32'h7FFF_FFFF, 0, 1, 0, '0, 0, '0);
    foreach (directed_rows[i])
      feed_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].report);

    hold_off_req = 1'b1;
    set_no = 0;
    while (words_fed < WORD_BUDGET) begin
      if (set_no == 4) size_of_set = CAPACITY;
      else if (set_no == 30) size_of_set = $urandom_range(CAPACITY + 1, CAPACITY + 20);
      else if ($urandom_range(0, 19) == 0) size_of_set = $urandom_range(20, 60);
      else size_of_set = $urandom_range(1, 10);
      keep = set_no != 4 && set_no != 30 && $urandom_range(0, 7) == 0;
      base = $urandom;
      if (words_fed < WORD_BUDGET - CALM_TAIL) begin
        src_idle_on   = $urandom_range(0, 2) != 0;
        sink_stall_on = $urandom_range(0, 2) != 0;
      end
      for (int i = 0; i < size_of_set; i++) begin
        if (words_fed >= WORD_BUDGET - CALM_TAIL) begin
          src_idle_on   = 1'b0;
          sink_stall_on = 1'b0;
        end
        w.value = pick_value(base);
        w.first = (i == 0) && !keep;
        w.last  = (i == size_of_set - 1) ? ($urandom_range(0, 7) != 0)
                                          : ($urandom_range(0, 15) == 0);
        feed_word(w, 1'b0, '0);
      end
      set_no++;
    end
    item_valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Fed %0d words in %0d cleared sets; checked %0d reports, %0d with dropped words.",
             words_fed, sets_started, reports_checked, drop_reports);
    if (mismatch_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin : sink_drive
    bit held;
    held = 1'b0;
    forever begin
      if (hold_off_req && !held) begin
        held = 1'b1;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (sink_stall_on && $urandom_range(0, 7) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : report_check
    mxt_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: report with no word pending: expected none, actual %h",
                 $time, result_data);
        mismatch_count++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (result_data.max_xor !== want.max_xor) begin
          $display("%0t: max_xor mismatch: expected %h, actual %h",
                   $time, want.max_xor, result_data.max_xor);
          mismatch_count++;
        end
        if (result_data.dropped !== want.dropped) begin
          $display("%0t: dropped mismatch: expected %b, actual %b",
                   $time, want.dropped, result_data.dropped);
          mismatch_count++;
        end
        if (result_data.word_count !== want.word_count) begin
          $display("%0t: word_count mismatch: expected %0d, actual %0d",
                   $time, want.word_count, result_data.word_count);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no word moved for %0d cycles, %0d reports pending",
             $time, QUIET_LIMIT, pending_reports.size());
    $display("Verification failed");
    $finish;
  end

endmodule
